// ----- src/bilinear_rgb_scaler_defines.svh -----
// Assertion macros for the bilinear RGB scaler.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BILINEAR_RGB_SCALER_DEFINES_SVH
`define BILINEAR_RGB_SCALER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge while reset is low.
`define BRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bilinear_rgb_scaler: check failed");
// Check a property on every clock edge, reset included.
`define BRS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bilinear_rgb_scaler: check failed");
`else
`define BRS_ASSERT(label, clk, rst, prop)
`define BRS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- src/brs_pkg.sv -----
// Package for the bilinear RGB scaler: widths, register reset values,
// register indexes and the channel extraction helper. No dependencies.
`timescale 1ns / 1ps

package brs_pkg;

   localparam int COORD_W     = 12;
   localparam int PIX_W       = 32;
   localparam int STEP_W      = 32;
   localparam int DIM_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int FRAC_W      = 4;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_TAPS    = 4;
   localparam int WEIGHT_W    = 9;
   localparam int PROD_W      = 44;
   localparam int POS_W       = 28;
   localparam int INT_POS_W   = POS_W - FRAC_W;
   localparam int TERM_W      = WEIGHT_W + CHAN_W;
   localparam int SUM_W       = TERM_W + 2;

   localparam logic [PROD_W-1:0]  POS_ROUND   = PROD_W'(32768);
   localparam logic [FRAC_W:0]    SUBPIX      = 5'd16;
   localparam logic [SUM_W-1:0]   CHAN_ROUND  = SUM_W'(128);

   localparam logic [STEP_W-1:0]  X_STEP_RESET     = 32'h0010_0000;
   localparam logic [STEP_W-1:0]  Y_STEP_RESET     = 32'h0010_0000;
   localparam logic [DIM_W-1:0]   SRC_WIDTH_RESET  = 13'd1;
   localparam logic [DIM_W-1:0]   SRC_HEIGHT_RESET = 13'd1;

   // Neighbor order inside the tap arrays.
   localparam int TAP_TL = 0;
   localparam int TAP_TR = 1;
   localparam int TAP_BL = 2;
   localparam int TAP_BR = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_STEP     = 2'd0,
      CSR_Y_STEP     = 2'd1,
      CSR_SRC_WIDTH  = 2'd2,
      CSR_SRC_HEIGHT = 2'd3
   } csr_index_type;

   typedef logic [PIX_W-1:0]    pixel_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [TERM_W-1:0]   term_type;

   // Pick one 8-bit channel of a 0RGB pixel, blue at index 0.
   function automatic logic [CHAN_W-1:0] chan(input pixel_type pix, input int idx);
      chan = pix[CHAN_W*idx +: CHAN_W];
   endfunction

endpackage

// ----- src/bilinear_rgb_scaler.sv -----
// Bilinear RGB scaler: 4-stage pipeline (s1, s2, s3 and the output registers).
// Throughput is one destination pixel per clock; busy never rises, so start
// may be held high every cycle. Each stage is two 32x12 multiplies, one wide
// add and compare, a row of 9x8 multiplies, or a channel sum and round.
// Synchronous reset clears the valid pipeline and loads the step and size
// registers with their defaults. Depends on brs_pkg and bilinear_rgb_scaler_defines.svh.
`timescale 1ns / 1ps
`include "bilinear_rgb_scaler_defines.svh"

module bilinear_rgb_scaler (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [brs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [brs_pkg::STEP_W-1:0]      csr_wdata,
   // pixel request channel
   input  logic                            start,
   output logic                            busy,
   input  logic [brs_pkg::COORD_W-1:0]     req_dest_col,
   input  logic [brs_pkg::COORD_W-1:0]     req_dest_row,
   input  logic [brs_pkg::PIX_W-1:0]       req_top_left_pixel,
   input  logic [brs_pkg::PIX_W-1:0]       req_top_right_pixel,
   input  logic [brs_pkg::PIX_W-1:0]       req_bottom_left_pixel,
   input  logic [brs_pkg::PIX_W-1:0]       req_bottom_right_pixel,
   // result channel
   output logic                            rsp_valid,
   output logic [brs_pkg::PIX_W-1:0]       rsp_out_pixel,
   output logic [brs_pkg::COORD_W-1:0]     rsp_src_col,
   output logic [brs_pkg::COORD_W-1:0]     rsp_src_row,
   output logic                            rsp_edge_copy
);
   import brs_pkg::*;

   // configuration registers
   logic [STEP_W-1:0] x_step_ff;
   logic [STEP_W-1:0] y_step_ff;
   logic [DIM_W-1:0]  src_width_ff;
   logic [DIM_W-1:0]  src_height_ff;

   // stage 1: position products
   logic              s1_valid_ff;
   logic [PROD_W-1:0] s1_xprod_ff, s1_xprod_in;
   logic [PROD_W-1:0] s1_yprod_ff, s1_yprod_in;
   pixel_type         s1_pix_ff [NUM_TAPS];

   // stage 2: integer position, edge test, area weights
   logic               s2_valid_ff;
   logic               s2_edge_ff, s2_edge_in;
   logic [COORD_W-1:0] s2_col_ff, s2_col_in;
   logic [COORD_W-1:0] s2_row_ff, s2_row_in;
   weight_type         s2_wt_ff [NUM_TAPS];
   weight_type         s2_wt_in [NUM_TAPS];
   pixel_type          s2_pix_ff [NUM_TAPS];

   // stage 3: weighted channel terms
   logic               s3_valid_ff;
   logic               s3_edge_ff;
   logic [COORD_W-1:0] s3_col_ff;
   logic [COORD_W-1:0] s3_row_ff;
   pixel_type          s3_top_left_ff;
   term_type           s3_term_ff [NUM_TAPS][NUM_CHAN];
   term_type           s3_term_in [NUM_TAPS][NUM_CHAN];

   // stage 4: output registers
   logic               rsp_valid_ff;
   pixel_type          rsp_pixel_ff, rsp_pixel_in;
   logic [COORD_W-1:0] rsp_col_ff;
   logic [COORD_W-1:0] rsp_row_ff;
   logic               rsp_edge_ff;

   logic accept;

   // never stall: one beat in per cycle, and config is taken at any time
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // config register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_step_ff     <= X_STEP_RESET;
         y_step_ff     <= Y_STEP_RESET;
         src_width_ff  <= SRC_WIDTH_RESET;
         src_height_ff <= SRC_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_X_STEP:     x_step_ff     <= csr_wdata;
            CSR_Y_STEP:     y_step_ff     <= csr_wdata;
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits advance through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: step times destination index
   assign s1_xprod_in = PROD_W'(x_step_ff) * PROD_W'(req_dest_col);
   assign s1_yprod_in = PROD_W'(y_step_ff) * PROD_W'(req_dest_row);

   always_ff @(posedge clock) begin
      s1_xprod_ff       <= s1_xprod_in;
      s1_yprod_ff       <= s1_yprod_in;
      s1_pix_ff[TAP_TL] <= req_top_left_pixel;
      s1_pix_ff[TAP_TR] <= req_top_right_pixel;
      s1_pix_ff[TAP_BL] <= req_bottom_left_pixel;
      s1_pix_ff[TAP_BR] <= req_bottom_right_pixel;
   end

   // stage 2: round to sixteenths, split, test the edges, form weights
   always_comb begin
      logic [PROD_W-1:0]    xsum;
      logic [PROD_W-1:0]    ysum;
      logic [POS_W-1:0]     xpos;
      logic [POS_W-1:0]     ypos;
      logic [INT_POS_W:0]   xnext;
      logic [INT_POS_W:0]   ynext;
      logic [FRAC_W:0]      xf;
      logic [FRAC_W:0]      yf;
      logic [FRAC_W:0]      xr;
      logic [FRAC_W:0]      yr;
      logic [2*FRAC_W+1:0]  w00;
      logic [2*FRAC_W+1:0]  w10;
      logic [2*FRAC_W+1:0]  w01;
      logic [2*FRAC_W+1:0]  w11;
      xsum  = s1_xprod_ff + POS_ROUND;
      ysum  = s1_yprod_ff + POS_ROUND;
      xpos  = xsum[PROD_W-1:PROD_W-POS_W];
      ypos  = ysum[PROD_W-1:PROD_W-POS_W];
      // full-width integer position plus two against the source size
      xnext = {1'b0, xpos[POS_W-1:FRAC_W]} + (INT_POS_W+1)'(2);
      ynext = {1'b0, ypos[POS_W-1:FRAC_W]} + (INT_POS_W+1)'(2);
      s2_edge_in = (xnext > (INT_POS_W+1)'(src_width_ff)) ||
                   (ynext > (INT_POS_W+1)'(src_height_ff));
      s2_col_in  = xpos[FRAC_W +: COORD_W];
      s2_row_in  = ypos[FRAC_W +: COORD_W];
      xf  = {1'b0, xpos[FRAC_W-1:0]};
      yf  = {1'b0, ypos[FRAC_W-1:0]};
      xr  = SUBPIX - xf;
      yr  = SUBPIX - yf;
      w00 = xr * yr;
      w10 = xf * yr;
      w01 = xr * yf;
      w11 = xf * yf;
      s2_wt_in[TAP_TL] = w00[WEIGHT_W-1:0];
      s2_wt_in[TAP_TR] = w10[WEIGHT_W-1:0];
      s2_wt_in[TAP_BL] = w01[WEIGHT_W-1:0];
      s2_wt_in[TAP_BR] = w11[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      s2_edge_ff <= s2_edge_in;
      s2_col_ff  <= s2_col_in;
      s2_row_ff  <= s2_row_in;
      s2_wt_ff   <= s2_wt_in;
      s2_pix_ff  <= s1_pix_ff;
   end

   // stage 3: weight times channel for every tap and channel
   always_comb begin
      for (int t = 0; t < NUM_TAPS; t++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            s3_term_in[t][c] = TERM_W'(s2_wt_ff[t]) * TERM_W'(chan(s2_pix_ff[t], c));
         end
      end
   end

   always_ff @(posedge clock) begin
      s3_edge_ff     <= s2_edge_ff;
      s3_col_ff      <= s2_col_ff;
      s3_row_ff      <= s2_row_ff;
      s3_top_left_ff <= s2_pix_ff[TAP_TL];
      s3_term_ff     <= s3_term_in;
   end

   // stage 4: sum, round and select the edge copy
   always_comb begin
      logic [SUM_W-1:0] sum;
      rsp_pixel_in = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum = SUM_W'(s3_term_ff[TAP_TL][c]) + SUM_W'(s3_term_ff[TAP_TR][c]) +
               SUM_W'(s3_term_ff[TAP_BL][c]) + SUM_W'(s3_term_ff[TAP_BR][c]) +
               CHAN_ROUND;
         rsp_pixel_in[CHAN_W*c +: CHAN_W] = sum[2*CHAN_W-1:CHAN_W];
      end
      if (s3_edge_ff) begin
         rsp_pixel_in = s3_top_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_col_ff   <= s3_col_ff;
      rsp_row_ff   <= s3_row_ff;
      rsp_edge_ff  <= s3_edge_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_src_col   = rsp_col_ff;
   assign rsp_src_row   = rsp_row_ff;
   assign rsp_edge_copy = rsp_edge_ff;

   // a blend beat always carries area weights that cover the whole pixel
   `BRS_ASSERT(a_weights_cover_pixel, clock, reset, s2_valid_ff && !s2_edge_ff |-> (10'(s2_wt_ff[TAP_TL]) + 10'(s2_wt_ff[TAP_TR]) + 10'(s2_wt_ff[TAP_BL]) + 10'(s2_wt_ff[TAP_BR])) == 10'd256)
   // a blended result never carries a top byte
   `BRS_ASSERT(a_blend_top_byte_zero, clock, reset, rsp_valid && !rsp_edge_copy |-> rsp_out_pixel[PIX_W-1:NUM_CHAN*CHAN_W] == '0)
   // the result strobe follows the last stage's valid in the next cycle
   `BRS_ASSERT(a_strobe_follows_stage, clock, reset, !$past(reset) |-> rsp_valid == $past(s3_valid_ff))
   // an edge copy passes the top-left pixel through unchanged
   `BRS_ASSERT(a_edge_copy_passes, clock, reset, s3_valid_ff && s3_edge_ff |=> rsp_out_pixel == $past(s3_top_left_ff))

endmodule

// ----- test/bilinear_rgb_scaler_tb.sv -----
// Self-checking testbench for bilinear_rgb_scaler: drives pixel requests and register
// writes, predicts each scaled pixel and checks every response beat in order.
// Depends on brs_pkg and the bilinear_rgb_scaler RTL.
`timescale 1ns / 1ps

module bilinear_rgb_scaler_tb;
   import brs_pkg::*;

   localparam int LATENCY     = 4;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      pixel_type            pixel;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic                 copied;
   } scaled_pixel_type;

   // Predicts scaled pixels from the register copy and checks responses in order.
   class scaler_scoreboard;
      logic [STEP_W-1:0] x_step, y_step;
      logic [DIM_W-1:0]  src_width, src_height;
      scaled_pixel_type  expected_pixels[$];
      int                mismatches, blends, copies;

      function new();
         x_step     = X_STEP_RESET;
         y_step     = Y_STEP_RESET;
         src_width  = SRC_WIDTH_RESET;
         src_height = SRC_HEIGHT_RESET;
         mismatches = 0;
         blends     = 0;
         copies     = 0;
      endfunction

      function void write_reg(input csr_index_type idx, input logic [STEP_W-1:0] data);
         case (idx)
            CSR_X_STEP:     x_step = data;
            CSR_Y_STEP:     y_step = data;
            CSR_SRC_WIDTH:  src_width = data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Map a destination index to sixteenths of a source pixel, rounded.
      function logic [63:0] subpixel_pos(input logic [STEP_W-1:0] step,
                                         input logic [COORD_W-1:0] idx);
         return (64'(step) * 64'(idx) + 64'd32768) >> 16;
      endfunction

      function void note_request(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                 input pixel_type tl, input pixel_type tr,
                                 input pixel_type bl, input pixel_type br);
         logic [63:0]      xpos, ypos, xint, yint;
         int               xf, yf, w_tl, w_tr, w_bl, w_br, sum, ch;
         scaled_pixel_type res;
         xpos = subpixel_pos(x_step, col);
         ypos = subpixel_pos(y_step, row);
         xint = xpos >> FRAC_W;
         yint = ypos >> FRAC_W;
         xf   = int'(xpos[FRAC_W-1:0]);
         yf   = int'(ypos[FRAC_W-1:0]);
         res.col = xint[COORD_W-1:0];
         res.row = yint[COORD_W-1:0];
         // Edge test uses the full position, not the reported 12 bits.
         res.copied = (xint + 64'd2 > 64'(src_width)) || (yint + 64'd2 > 64'(src_height));
         if (res.copied) begin
            res.pixel = tl;
         end else begin
            w_tl = (16 - xf) * (16 - yf);
            w_tr = xf * (16 - yf);
            w_bl = (16 - xf) * yf;
            w_br = xf * yf;
            res.pixel = '0;
            for (ch = 0; ch < NUM_CHAN; ch++) begin
               sum = w_tl * int'(tl[8*ch +: 8]) + w_tr * int'(tr[8*ch +: 8])
                   + w_bl * int'(bl[8*ch +: 8]) + w_br * int'(br[8*ch +: 8]) + 128;
               res.pixel[8*ch +: 8] = sum[15:8];
            end
         end
         expected_pixels.push_back(res);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(input pixel_type pixel, input logic [COORD_W-1:0] col,
                                 input logic [COORD_W-1:0] row, input logic copied);
         scaled_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got pixel %h col %h row %h copy %b",
                     $time, pixel, col, row, copied);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         if (want.copied) copies++;
         else blends++;
         compare_field("out_pixel", want.pixel, pixel);
         compare_field("src_col", 32'(want.col), 32'(col));
         compare_field("src_row", 32'(want.row), 32'(row));
         compare_field("edge_copy", 32'(want.copied), 32'(copied));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [STEP_W-1:0]    csr_wdata;
   logic                 start;
   logic                 busy;
   logic [COORD_W-1:0]   req_dest_col;
   logic [COORD_W-1:0]   req_dest_row;
   pixel_type            req_top_left_pixel;
   pixel_type            req_top_right_pixel;
   pixel_type            req_bottom_left_pixel;
   pixel_type            req_bottom_right_pixel;
   logic                 rsp_valid;
   pixel_type            rsp_out_pixel;
   logic [COORD_W-1:0]   rsp_src_col;
   logic [COORD_W-1:0]   rsp_src_row;
   logic                 rsp_edge_copy;

   scaler_scoreboard board = new();
   int               cycle_count = 0;
   int               settings_run = 0;

   bilinear_rgb_scaler u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .start                  (start),
      .busy                   (busy),
      .req_dest_col           (req_dest_col),
      .req_dest_row           (req_dest_row),
      .req_top_left_pixel     (req_top_left_pixel),
      .req_top_right_pixel    (req_top_right_pixel),
      .req_bottom_left_pixel  (req_bottom_left_pixel),
      .req_bottom_right_pixel (req_bottom_right_pixel),
      .rsp_valid              (rsp_valid),
      .rsp_out_pixel          (rsp_out_pixel),
      .rsp_src_col            (rsp_src_col),
      .rsp_src_row            (rsp_src_row),
      .rsp_edge_copy          (rsp_edge_copy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note accepted request beats and check response beats.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_request(req_dest_col, req_dest_row, req_top_left_pixel,
                               req_top_right_pixel, req_bottom_left_pixel,
                               req_bottom_right_pixel);
         if (rsp_valid)
            board.check_result(rsp_out_pixel, rsp_src_col, rsp_src_row, rsp_edge_copy);
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bilinear_rgb_scaler test failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                             input pixel_type tl, input pixel_type tr,
                             input pixel_type bl, input pixel_type br);
      @(negedge clock);
      start                  <= 1'b1;
      req_dest_col           <= col;
      req_dest_row           <= row;
      req_top_left_pixel     <= tl;
      req_top_right_pixel    <= tr;
      req_bottom_left_pixel  <= bl;
      req_bottom_right_pixel <= br;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Drop start and hold until every expected beat has arrived.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [STEP_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys,
                            input int w, input int h);
      drain();
      write_csr(CSR_X_STEP, xs);
      write_csr(CSR_Y_STEP, ys);
      write_csr(CSR_SRC_WIDTH, STEP_W'(w));
      write_csr(CSR_SRC_HEIGHT, STEP_W'(h));
      settings_run++;
   endtask

   // Pick an image dimension: mostly modest, sometimes the extremes.
   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 4096;
      if (r == 1) return 1;
      return $urandom_range(2, 300);
   endfunction

   // Step in Q16 sixteenths: 16 * src / dst, rounded and saturated to 32 bits.
   function automatic logic [STEP_W-1:0] step_for(input int src, input int dst);
      longint q;
      q = ((longint'(src) * 16) * 65536 + dst / 2) / dst;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : STEP_W'(q);
   endfunction

   initial begin
      int idle_pct[3] = '{0, 73, 24};
      int src_w, src_h, dst_w, dst_h, ph, i, idle;
      logic [STEP_W-1:0] xs, ys;
      logic [COORD_W-1:0] col, row;

      reset                  = 1'b1;
      csr_valid              = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      start                  = 1'b0;
      req_dest_col           = '0;
      req_dest_row           = '0;
      req_top_left_pixel     = '0;
      req_top_right_pixel    = '0;
      req_bottom_left_pixel  = '0;
      req_bottom_right_pixel = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a 1x1 source, so every pixel is an edge copy.
      send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_pixel(12'd4095, 12'd4095, 32'hA512_3456, $urandom(), $urandom(), $urandom());
      send_pixel(12'd1, 12'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // One sixteenth per index: the fraction follows the low index bits.
      configure(32'h0001_0000, 32'h0001_0000, 4096, 4096);
      send_pixel(12'd0, 12'd0, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0);
      send_pixel(12'd15, 12'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_pixel(12'd0, 12'd15, 32'h0, 32'h0, 32'h00FF_FFFF, 32'h00FF_FFFF);
      send_pixel(12'd15, 12'd15, 32'h0, 32'h0, 32'h0, 32'h00FF_FFFF);
      send_pixel(12'd8, 12'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(12'd4095, 12'd4095, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd7, 12'd9, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd0, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0);

      // 3x3 source: the last column and row would copy; these points, up to one short of them, blend.
      configure(32'h0001_0000, 32'h0001_0000, 3, 3);
      send_pixel(12'd16, 12'd0, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd15, 12'd31, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd15, 12'd15, $urandom(), $urandom(), $urandom(), $urandom());

      // Zero and full steps: positions far beyond twelve bits wrap in the report.
      configure(32'h0, 32'hFFFF_FFFF, 2, 4096);
      send_pixel(12'd5, 12'd0, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd4095, 12'd1, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd0, 12'd4095, $urandom(), $urandom(), $urandom(), $urandom());
      configure(32'hFFFF_FFFF, 32'h0, 4096, 2);
      send_pixel(12'd4095, 12'd7, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd0, 12'd0, $urandom(), $urandom(), $urandom(), $urandom());
      send_pixel(12'd1, 12'd4095, $urandom(), $urandom(), $urandom(), $urandom());

      // Random scale settings, mostly coordinates inside the destination image.
      for (ph = 0; ph < 12; ph++) begin
         src_w = pick_dim();
         src_h = pick_dim();
         dst_w = pick_dim();
         dst_h = pick_dim();
         xs = ($urandom_range(0, 5) == 0) ? $urandom() : step_for(src_w, dst_w);
         ys = ($urandom_range(0, 5) == 0) ? $urandom() : step_for(src_h, dst_h);
         configure(xs, ys, src_w, src_h);
         idle = idle_pct[ph % 3];
         for (i = 0; i < 75; i++) begin
            if (ph % 4 == 1 && i == 37)
               drain();
            if ($urandom_range(0, 9) < 8) begin
               col = COORD_W'($urandom_range(0, dst_w - 1));
               row = COORD_W'($urandom_range(0, dst_h - 1));
            end else begin
               col = COORD_W'($urandom_range(0, 4095));
               row = COORD_W'($urandom_range(0, 4095));
            end
            // idle each cycle with the phase's odds, so that share of cycles stays empty
            while ($urandom_range(0, 99) < idle)
               idle_cycles(1);
            send_pixel(col, row, $urandom(), $urandom(), $urandom(), $urandom());
         end
      end

      drain();
      repeat (LATENCY) @(posedge clock);
      $display("Scaled %0d pixels under %0d register settings: %0d blended, %0d edge copies.",
               board.blends + board.copies, settings_run, board.blends, board.copies);
      if (board.mismatches == 0) begin
         $display("bilinear_rgb_scaler test passed");
      end else begin
         $display("bilinear_rgb_scaler test failed");
      end
      $finish;
   end

endmodule
